/* src/hsl_to_rgb_converter_unit_macros.svh */
// Assertion macros used by the checker file of the HSL to RGB converter.
// Included by bare file name; no other dependencies.
`ifndef HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// Property checked on every rising edge, ignored while reset is asserted
`define HSL2RGB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset cycles included
`define HSL2RGB_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/hsl2rgb_pkg.sv */
// Shared types, widths and helper functions of the HSL to RGB converter.
// No dependencies; used by every module of the block.
package hsl2rgb_pkg;

  // Fixed-point format of saturation, lightness and the internal levels
  localparam int FRACTION_BITS = 16;
  localparam int LVL_W         = FRACTION_BITS + 1;   // 0 .. ONE
  localparam int SL_W          = 18;                  // saturation/lightness field
  localparam int CMP_W         = (FRACTION_BITS + 2 > SL_W) ? FRACTION_BITS + 2 : SL_W;
  localparam int SUM_W         = LVL_W + 2;           // signed level sums
  localparam logic [LVL_W-1:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [LVL_W-1:0] HALF = ONE >> 1;

  // Hue: fraction of a turn, handled in sixths
  localparam int HUE_W  = 16;
  localparam int FRAC_W = HUE_W;                      // position inside a sextant
  localparam int SEXT_W = 3;
  localparam int H6_W   = HUE_W + SEXT_W;
  localparam int WGT_W  = FRAC_W + 1;
  localparam logic [WGT_W-1:0] SIXTH = {1'b1, {FRAC_W{1'b0}}};

  // Sextant arithmetic
  localparam logic [SEXT_W-1:0] TURN_SEXT  = SEXT_W'(6);
  localparam logic [SEXT_W-1:0] THIRD_SEXT = SEXT_W'(2);
  localparam logic [SEXT_W-1:0] SEXT_RISE  = SEXT_W'(0);
  localparam logic [SEXT_W-1:0] SEXT_TOP_A = SEXT_W'(1);
  localparam logic [SEXT_W-1:0] SEXT_TOP_B = SEXT_W'(2);
  localparam logic [SEXT_W-1:0] SEXT_FALL  = SEXT_W'(3);

  localparam int BYTE_W = 8;
  localparam int NCH    = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Item queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Piece of the hue ramp a channel sits on
  typedef enum logic [1:0] {
    RAMP_UP,
    RAMP_HI,
    RAMP_DN,
    RAMP_LO
  } ramp_t;

  // Classified item as queued by the front
  typedef struct packed {
    ramp_t [NCH-1:0]     ramp;
    logic [FRAC_W-1:0]   frac;
    logic [LVL_W-1:0]    sat;
    logic [LVL_W-1:0]    lit;
    logic [BYTE_W-1:0]   alpha;
  } item_t;

  // Clamp a signed input field to [0, ONE]
  function automatic logic [LVL_W-1:0] clamp_in(input logic signed [SL_W-1:0] x);
    logic signed [CMP_W-1:0] xe;
    logic [LVL_W-1:0]        res;
    xe = CMP_W'(x);
    if (xe[CMP_W-1]) begin
      res = '0;
    end else if (xe > signed'(CMP_W'(ONE))) begin
      res = ONE;
    end else begin
      res = LVL_W'(xe);
    end
    return res;
  endfunction

  // Clamp a signed level sum to [0, ONE]
  function automatic logic [LVL_W-1:0] clamp_sum(input logic signed [SUM_W-1:0] x);
    logic [LVL_W-1:0] res;
    if (x[SUM_W-1]) begin
      res = '0;
    end else if (x > signed'(SUM_W'(ONE))) begin
      res = ONE;
    end else begin
      res = LVL_W'(x);
    end
    return res;
  endfunction

  // Map a sextant to its ramp piece
  function automatic ramp_t sextant_ramp(input logic [SEXT_W-1:0] k);
    ramp_t r;
    unique case (k)
      SEXT_RISE:              r = RAMP_UP;
      SEXT_TOP_A, SEXT_TOP_B: r = RAMP_HI;
      SEXT_FALL:              r = RAMP_DN;
      default:                r = RAMP_LO;
    endcase
    return r;
  endfunction

  // floor(clamp(v) * 255 / ONE)
  function automatic logic [BYTE_W-1:0] to_byte(input logic [LVL_W:0] v);
    logic [LVL_W-1:0]        c;
    logic [LVL_W+BYTE_W-1:0] sc;
    c  = (v > {1'b0, ONE}) ? ONE : v[LVL_W-1:0];
    sc = {c, {BYTE_W{1'b0}}} - (LVL_W + BYTE_W)'(c);
    return sc[FRACTION_BITS +: BYTE_W];
  endfunction

endpackage

/* src/hsl2rgb_front.sv */
// Front end: clamps saturation and lightness and classifies the hue into
// the ramp piece of each channel. Depends on hsl2rgb_pkg.
module hsl2rgb_front (
  input  logic [hsl2rgb_pkg::HUE_W-1:0]       in_hue,
  input  logic signed [hsl2rgb_pkg::SL_W-1:0] in_saturation,
  input  logic signed [hsl2rgb_pkg::SL_W-1:0] in_lightness,
  input  logic [hsl2rgb_pkg::BYTE_W-1:0]      in_alpha_in,
  output hsl2rgb_pkg::item_t                  item
);

  logic [hsl2rgb_pkg::H6_W-1:0]   h6;
  logic [hsl2rgb_pkg::SEXT_W-1:0] k_g;
  logic [hsl2rgb_pkg::SEXT_W-1:0] k_r;
  logic [hsl2rgb_pkg::SEXT_W-1:0] k_b;

  // hue * 6: sextant in the top bits, position in the low bits
  assign h6  = hsl2rgb_pkg::H6_W'({in_hue, 2'b00}) + hsl2rgb_pkg::H6_W'({in_hue, 1'b0});
  assign k_g = h6[hsl2rgb_pkg::H6_W-1 -: hsl2rgb_pkg::SEXT_W];

  // red is a third ahead, blue a third behind, both modulo a turn
  assign k_r = (k_g >= hsl2rgb_pkg::TURN_SEXT - hsl2rgb_pkg::THIRD_SEXT) ?
               k_g - (hsl2rgb_pkg::TURN_SEXT - hsl2rgb_pkg::THIRD_SEXT) :
               k_g + hsl2rgb_pkg::THIRD_SEXT;
  assign k_b = (k_g >= hsl2rgb_pkg::THIRD_SEXT) ?
               k_g - hsl2rgb_pkg::THIRD_SEXT :
               k_g + (hsl2rgb_pkg::TURN_SEXT - hsl2rgb_pkg::THIRD_SEXT);

  // classified item
  always_comb begin
    item = '0;
    item.ramp[hsl2rgb_pkg::CH_RED]   = hsl2rgb_pkg::sextant_ramp(k_r);
    item.ramp[hsl2rgb_pkg::CH_GREEN] = hsl2rgb_pkg::sextant_ramp(k_g);
    item.ramp[hsl2rgb_pkg::CH_BLUE]  = hsl2rgb_pkg::sextant_ramp(k_b);
    item.frac  = h6[hsl2rgb_pkg::FRAC_W-1:0];
    item.sat   = hsl2rgb_pkg::clamp_in(in_saturation);
    item.lit   = hsl2rgb_pkg::clamp_in(in_lightness);
    item.alpha = in_alpha_in;
  end

endmodule

/* src/hsl2rgb_fifo.sv */
// Short item queue between front and back, flop based.
// Depends on hsl2rgb_pkg.
module hsl2rgb_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  hsl2rgb_pkg::item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output hsl2rgb_pkg::item_t pop_item
);

  hsl2rgb_pkg::item_t                   mem_r [hsl2rgb_pkg::QDEPTH];
  logic [hsl2rgb_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [hsl2rgb_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [hsl2rgb_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic                                 push, pop;

  localparam logic [hsl2rgb_pkg::QPTR_W-1:0] LAST = hsl2rgb_pkg::QPTR_W'(hsl2rgb_pkg::QDEPTH - 1);

  assign push_ready = (cnt_r != hsl2rgb_pkg::QCNT_W'(hsl2rgb_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* src/hsl2rgb_back.sv */
// Back end: five-stage pipeline from a classified item to the color bytes;
// the last stage is the output register. Depends on hsl2rgb_pkg.
module hsl2rgb_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  hsl2rgb_pkg::item_t                pop_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]    out_alpha_out,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]    out_red,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]    out_green,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]    out_blue
);

  localparam int LW   = hsl2rgb_pkg::LVL_W;
  localparam int FB   = hsl2rgb_pkg::FRACTION_BITS;
  localparam int FW   = hsl2rgb_pkg::FRAC_W;
  localparam int WW   = hsl2rgb_pkg::WGT_W;
  localparam int BW   = hsl2rgb_pkg::BYTE_W;
  localparam int SW   = hsl2rgb_pkg::SUM_W;
  localparam int NCH  = hsl2rgb_pkg::NCH;
  localparam int NSTG = 5;

  typedef struct packed {
    logic [LW-1:0]                    ls;
    logic [LW-1:0]                    lit;
    logic [LW-1:0]                    sat;
    logic                             low;
    hsl2rgb_pkg::ramp_t [NCH-1:0]     ramp;
    logic [FW-1:0]                    frac;
    logic [BW-1:0]                    alpha;
  } stg_a_t;

  typedef struct packed {
    logic [LW-1:0]                    m2;
    logic [LW-1:0]                    lit;
    hsl2rgb_pkg::ramp_t [NCH-1:0]     ramp;
    logic [FW-1:0]                    frac;
    logic [BW-1:0]                    alpha;
  } stg_b_t;

  typedef struct packed {
    logic [LW-1:0]                    m1;
    logic [LW-1:0]                    m2;
    logic [LW-1:0]                    d;
    hsl2rgb_pkg::ramp_t [NCH-1:0]     ramp;
    logic [FW-1:0]                    frac;
    logic [BW-1:0]                    alpha;
  } stg_c_t;

  typedef struct packed {
    logic [LW-1:0]                    m1;
    logic [LW-1:0]                    m2;
    logic [NCH-1:0][LW-1:0]           part;
    hsl2rgb_pkg::ramp_t [NCH-1:0]     ramp;
    logic [BW-1:0]                    alpha;
  } stg_d_t;

  typedef struct packed {
    logic [NCH-1:0][BW-1:0]           chan;
    logic [BW-1:0]                    alpha;
  } stg_e_t;

  // ramp weight: rising uses f, falling uses one sixth minus f
  function automatic logic [WW-1:0] ramp_weight(input hsl2rgb_pkg::ramp_t r,
                                                input logic [FW-1:0] f);
    logic [WW-1:0] w;
    unique case (r)
      hsl2rgb_pkg::RAMP_UP: w = {1'b0, f};
      hsl2rgb_pkg::RAMP_DN: w = hsl2rgb_pkg::SIXTH - {1'b0, f};
      default:              w = '0;
    endcase
    return w;
  endfunction

  // channel level before the final clamp
  function automatic logic [LW:0] ramp_level(input hsl2rgb_pkg::ramp_t r,
                                             input logic [LW-1:0] m1,
                                             input logic [LW-1:0] m2,
                                             input logic [LW-1:0] part);
    logic [LW:0] v;
    unique case (r)
      hsl2rgb_pkg::RAMP_UP,
      hsl2rgb_pkg::RAMP_DN: v = {1'b0, m1} + {1'b0, part};
      hsl2rgb_pkg::RAMP_HI: v = {1'b0, m2};
      default:              v = {1'b0, m1};
    endcase
    return v;
  endfunction

  logic [NSTG-1:0]          vld_r, vld_nxt;
  logic                     adv;
  stg_a_t                   a_r, a_nxt;
  stg_b_t                   b_r, b_nxt;
  stg_c_t                   c_r, c_nxt;
  stg_d_t                   d_r, d_nxt;
  stg_e_t                   e_r, e_nxt;
  logic [2*LW-1:0]          ls_prod;
  logic signed [SW-1:0]     m2_sum;
  logic signed [SW-1:0]     m1_sum;
  logic signed [SW-1:0]     d_sum;
  logic [LW-1:0]            m1_clamped;
  logic [NCH-1:0][LW+WW-1:0] ramp_prod;

  // whole pipeline moves unless the output register holds an untaken result
  assign adv       = !vld_r[NSTG-1] || out_ready;
  assign pop_ready = adv;
  assign vld_nxt   = {vld_r[NSTG-2:0], pop_valid};

  // stage A: l * s
  always_comb begin
    ls_prod     = (2*LW)'(pop_item.lit) * (2*LW)'(pop_item.sat);
    a_nxt.ls    = ls_prod[FB +: LW];
    a_nxt.lit   = pop_item.lit;
    a_nxt.sat   = pop_item.sat;
    a_nxt.low   = (pop_item.lit <= hsl2rgb_pkg::HALF);
    a_nxt.ramp  = pop_item.ramp;
    a_nxt.frac  = pop_item.frac;
    a_nxt.alpha = pop_item.alpha;
  end

  // stage B: high level m2
  always_comb begin
    if (a_r.low) begin
      m2_sum = $signed({2'b00, a_r.lit}) + $signed({2'b00, a_r.ls});
    end else begin
      m2_sum = $signed({2'b00, a_r.lit}) + $signed({2'b00, a_r.sat})
             - $signed({2'b00, a_r.ls});
    end
    b_nxt.m2    = hsl2rgb_pkg::clamp_sum(m2_sum);
    b_nxt.lit   = a_r.lit;
    b_nxt.ramp  = a_r.ramp;
    b_nxt.frac  = a_r.frac;
    b_nxt.alpha = a_r.alpha;
  end

  // stage C: low level m1 = 2l - m2 and ramp height
  always_comb begin
    m1_sum      = $signed({1'b0, b_r.lit, 1'b0}) - $signed({2'b00, b_r.m2});
    m1_clamped  = hsl2rgb_pkg::clamp_sum(m1_sum);
    d_sum       = $signed({2'b00, b_r.m2}) - $signed({2'b00, m1_clamped});
    c_nxt.m1    = m1_clamped;
    c_nxt.m2    = b_r.m2;
    c_nxt.d     = hsl2rgb_pkg::clamp_sum(d_sum);
    c_nxt.ramp  = b_r.ramp;
    c_nxt.frac  = b_r.frac;
    c_nxt.alpha = b_r.alpha;
  end

  // stage D: one ramp multiply per channel
  always_comb begin
    d_nxt.m1    = c_r.m1;
    d_nxt.m2    = c_r.m2;
    d_nxt.ramp  = c_r.ramp;
    d_nxt.alpha = c_r.alpha;
    for (int c = 0; c < NCH; c++) begin
      ramp_prod[c]  = (LW+WW)'(c_r.d) * (LW+WW)'(ramp_weight(c_r.ramp[c], c_r.frac));
      d_nxt.part[c] = ramp_prod[c][FW +: LW];
    end
  end

  // stage E: select level, clamp, scale to a byte
  always_comb begin
    e_nxt.alpha = d_r.alpha;
    for (int c = 0; c < NCH; c++) begin
      e_nxt.chan[c] = hsl2rgb_pkg::to_byte(
                        ramp_level(d_r.ramp[c], d_r.m1, d_r.m2, d_r.part[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
      e_r <= e_nxt;
    end
  end

  assign out_valid     = vld_r[NSTG-1];
  assign out_alpha_out = e_r.alpha;
  assign out_red       = e_r.chan[hsl2rgb_pkg::CH_RED];
  assign out_green     = e_r.chan[hsl2rgb_pkg::CH_GREEN];
  assign out_blue      = e_r.chan[hsl2rgb_pkg::CH_BLUE];

endmodule

/* src/hsl_to_rgb_converter_unit.sv */
// Top level of the HSL to RGB converter: front classifier, item queue and
// back pipeline. Depends on hsl2rgb_pkg and the hsl2rgb_* modules.
//
//   channel   handshake              payload
//   in        in_valid / in_ready    in_hue, in_saturation, in_lightness, in_alpha_in
//   out       out_valid / out_ready  out_alpha_out, out_red, out_green, out_blue
//
// One item per clock sustained while the output is not stalled; an accepted
// item passes the queue, the registers of stages A to D and then the stage E
// output register on its way to out_valid. The pipeline holds a single l*s
// multiplier and one ramp multiplier per channel.
// Reset (rst_n low, synchronous) empties the queue and the pipeline.
// A stalled output freezes the pipeline; the two-entry queue keeps taking
// items until it is full, so in_ready drops only after an output stall.
module hsl_to_rgb_converter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hsl2rgb_pkg::HUE_W-1:0]       in_hue,
  input  logic signed [hsl2rgb_pkg::SL_W-1:0] in_saturation,
  input  logic signed [hsl2rgb_pkg::SL_W-1:0] in_lightness,
  input  logic [hsl2rgb_pkg::BYTE_W-1:0]      in_alpha_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]      out_alpha_out,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]      out_red,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]      out_green,
  output logic [hsl2rgb_pkg::BYTE_W-1:0]      out_blue
);

  hsl2rgb_pkg::item_t front_item;
  hsl2rgb_pkg::item_t q_item;
  logic               q_valid;
  logic               q_ready;

  // classify
  hsl2rgb_front u_front (
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_lightness  (in_lightness),
    .in_alpha_in   (in_alpha_in),
    .item          (front_item)
  );

  // decouple
  hsl2rgb_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // compute
  hsl2rgb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (q_valid),
    .pop_ready     (q_ready),
    .pop_item      (q_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_alpha_out (out_alpha_out),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

endmodule

/* src/hsl2rgb_checker.sv */
// Port-level checks for the HSL to RGB converter, bound to the top level.
// Depends on hsl_to_rgb_converter_unit_macros.svh.
`include "hsl_to_rgb_converter_unit_macros.svh"

module hsl2rgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_alpha_out,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // a stalled result stays put
  `HSL2RGB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_alpha_out) && $stable(out_red) && $stable(out_green) && $stable(out_blue), "stalled result changed")

  // a result leaves only when taken
  `HSL2RGB_ASSERT(a_out_drop, clk, rst_n, $fell(out_valid) |-> $past(out_ready), "result dropped without being taken")

  // the queue fills up only behind an output stall
  `HSL2RGB_ASSERT(a_in_stall, clk, rst_n, !in_ready |-> $past(out_valid && !out_ready), "input stalled without an output stall")

  // reset empties queue and pipeline
  `HSL2RGB_ASSERT_ANY(a_reset_empty, clk, !rst_n |=> !out_valid && in_ready, "block not empty after reset")

endmodule

bind hsl_to_rgb_converter_unit hsl2rgb_checker u_hsl2rgb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_alpha_out (out_alpha_out),
  .out_red       (out_red),
  .out_green     (out_green),
  .out_blue      (out_blue)
);

/* verif/tb_top.sv */
// Self-checking testbench for hsl_to_rgb_converter_unit: HSL plus alpha items in, ARGB bytes out.
// Depends on hsl2rgb_pkg and the RTL of the block; carries its own color predictor.
module tb_top;

  localparam int  HUE_W  = hsl2rgb_pkg::HUE_W;
  localparam int  SL_W   = hsl2rgb_pkg::SL_W;
  localparam int  BYTE_W = hsl2rgb_pkg::BYTE_W;
  localparam int  FRAC_B = hsl2rgb_pkg::FRACTION_BITS;
  localparam longint LEVEL_ONE  = longint'(1) << FRAC_B;
  localparam longint LEVEL_HALF = LEVEL_ONE >> 1;
  // hue is handled in sixths of a turn
  localparam longint SIXTH_UNITS = longint'(1) << HUE_W;
  localparam longint TURN_UNITS  = 6 * SIXTH_UNITS;
  localparam longint THIRD_UNITS = 2 * SIXTH_UNITS;

  localparam int GAP_MAX       = 13;
  localparam int HOLD_CYCLES   = 64;
  localparam int DRAIN_CYCLES  = 24;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_BLOCKS = 14;
  localparam int BLOCK_ITEMS   = 100;

  typedef struct packed {
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } argb_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [HUE_W-1:0]       in_hue;
  logic signed [SL_W-1:0] in_saturation;
  logic signed [SL_W-1:0] in_lightness;
  logic [BYTE_W-1:0]      in_alpha_in;
  logic out_valid;
  logic out_ready;
  logic [BYTE_W-1:0] out_alpha_out;
  logic [BYTE_W-1:0] out_red;
  logic [BYTE_W-1:0] out_green;
  logic [BYTE_W-1:0] out_blue;

  argb_t expected_colors[$];
  int    items_sent;
  int    colors_checked;
  int    fail_count;
  int    idle_cycles;
  int    send_gap_max;
  int    recv_gap_max;
  bit    hold_request;

  hsl_to_rgb_converter_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_lightness (in_lightness),
    .in_alpha_in  (in_alpha_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_alpha_out(out_alpha_out),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Color prediction

  function automatic longint clamp_level(input longint x);
    if (x < 0) return 0;
    if (x > LEVEL_ONE) return LEVEL_ONE;
    return x;
  endfunction

  // piecewise hue ramp between the low and high levels
  function automatic longint hue_ramp(input longint h6, input longint m1, input longint m2);
    longint sext;
    longint frac;
    longint span;
    sext = h6 / SIXTH_UNITS;
    frac = h6 % SIXTH_UNITS;
    span = (m2 > m1) ? m2 - m1 : 0;
    case (sext)
      0:       return m1 + (span * frac) / SIXTH_UNITS;
      1, 2:    return m2;
      3:       return m1 + (span * (SIXTH_UNITS - frac)) / SIXTH_UNITS;
      default: return m1;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] level_byte(input longint v);
    return BYTE_W'((clamp_level(v) * 255) / LEVEL_ONE);
  endfunction

  function automatic argb_t predict_argb(input logic [HUE_W-1:0] hue,
                                         input logic signed [SL_W-1:0] sat,
                                         input logic signed [SL_W-1:0] lit,
                                         input logic [BYTE_W-1:0] alpha);
    longint s, l, m1, m2, h6, hr, hb, sat_x, lit_x;
    argb_t c;
    sat_x = sat;
    lit_x = lit;
    s  = clamp_level(sat_x);
    l  = clamp_level(lit_x);
    if (2 * l <= LEVEL_ONE) m2 = (l * (LEVEL_ONE + s)) >> FRAC_B;
    else                    m2 = l + s - ((l * s) >> FRAC_B);
    m2 = clamp_level(m2);
    m1 = clamp_level(2 * l - m2);
    h6 = longint'(hue) * 6;
    hr = h6 + THIRD_UNITS;
    if (hr >= TURN_UNITS) hr -= TURN_UNITS;
    hb = h6 - THIRD_UNITS;
    if (hb < 0) hb += TURN_UNITS;
    c.alpha = alpha;
    c.red   = level_byte(hue_ramp(hr, m1, m2));
    c.green = level_byte(hue_ramp(h6, m1, m2));
    c.blue  = level_byte(hue_ramp(hb, m1, m2));
    return c;
  endfunction

  task automatic check_field(input string name, input logic [BYTE_W-1:0] exp_v,
                             input logic [BYTE_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result checking, prediction on acceptance, and stall watchdog
  always @(posedge clk) begin : check_results
    argb_t exp_c;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $error("color result with no item pending");
          fail_count++;
        end else begin
          exp_c = expected_colors.pop_front();
          check_field("alpha_out", exp_c.alpha, out_alpha_out);
          check_field("red",       exp_c.red,   out_red);
          check_field("green",     exp_c.green, out_green);
          check_field("blue",      exp_c.blue,  out_blue);
          colors_checked++;
        end
      end
      if (in_valid && in_ready) begin
        expected_colors.push_back(predict_argb(in_hue, in_saturation, in_lightness,
                                               in_alpha_in));
        items_sent++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Result side: random stalls per item, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      gap = $urandom_range(0, recv_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one item; returns once it is accepted
  task automatic send_color(input logic [HUE_W-1:0] hue, input logic signed [SL_W-1:0] sat,
                            input logic signed [SL_W-1:0] lit,
                            input logic [BYTE_W-1:0] alpha);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_lightness  <= lit;
    in_alpha_in   <= alpha;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly legal levels, some edges, some anything the field holds
  function automatic logic signed [SL_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0: return SL_W'($urandom());
      1: begin
        case ($urandom_range(0, 6))
          0:       return '0;
          1:       return SL_W'(LEVEL_ONE);
          2:       return SL_W'(LEVEL_ONE - 1);
          3:       return SL_W'(LEVEL_ONE + 1);
          4:       return '1;
          5:       return SL_W'(LEVEL_HALF);
          default: return SL_W'(LEVEL_HALF + 1);
        endcase
      end
      default: return SL_W'($urandom_range(0, int'(LEVEL_ONE)));
    endcase
  endfunction

  // Corners: field extremes, sextant and third-of-turn edges, clamping
  task automatic test_directed_corners();
    logic signed [SL_W-1:0] s_max, s_min, one, half;
    s_max = {1'b0, {(SL_W-1){1'b1}}};
    s_min = {1'b1, {(SL_W-1){1'b0}}};
    one   = SL_W'(LEVEL_ONE);
    half  = SL_W'(LEVEL_HALF);
    send_gap_max = 0;
    recv_gap_max = 0;
    send_color(16'd0,     one, half, 8'h00);
    send_color(16'hFFFF,  one, half, 8'hFF);
    send_color(16'd10922, one, half, 8'h01);
    send_color(16'd10923, one, half, 8'h80);
    send_color(16'd21845, one, half, 8'h7F);
    send_color(16'd21846, one, half, 8'hFE);
    // shifted hue just under and just past a full turn
    send_color(16'd43690, one, half, 8'h55);
    send_color(16'd43691, one, half, 8'hAA);
    send_color(16'd32768, one, half, 8'h33);
    send_color(16'd32767, one, SL_W'(LEVEL_HALF + 1), 8'hCC);
    // out-of-range levels, both signs
    send_color(16'd5000,  s_min, s_max, 8'h0F);
    send_color(16'd5000,  s_max, s_min, 8'hF0);
    send_color(16'd30000, '1, SL_W'(LEVEL_ONE + 1), 8'h3C);
    send_color(16'd30000, SL_W'(LEVEL_ONE + 1), '1, 8'hC3);
    send_color(16'd60000, s_max, s_max, 8'h11);
    send_color(16'd60000, s_min, s_min, 8'hEE);
    // gray, black, white
    send_color(16'd12345, '0, SL_W'(LEVEL_ONE / 3), 8'h22);
    send_color(16'd40000, one, '0, 8'h44);
    send_color(16'd50000, one, one, 8'h88);
    send_color(16'd20000, SL_W'(LEVEL_ONE - 1), SL_W'(LEVEL_ONE - 1), 8'h99);
    send_color(16'd7000,  SL_W'(1), SL_W'(LEVEL_HALF - 1), 8'h66);
  endtask

  // Output stalled for a long stretch while input keeps coming
  task automatic test_back_pressure();
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_request = 1'b1;
    repeat (40) send_color(HUE_W'($urandom()), rand_level(), rand_level(),
                           BYTE_W'($urandom()));
  endtask

  // Random items in blocks, each with its own idling mix
  task automatic test_random_colors();
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case ($urandom_range(0, 3))
        0:       send_gap_max = 0;
        1:       send_gap_max = 3;
        default: send_gap_max = GAP_MAX;
      endcase
      case ($urandom_range(0, 3))
        0:       recv_gap_max = 0;
        1:       recv_gap_max = 3;
        default: recv_gap_max = GAP_MAX;
      endcase
      repeat (BLOCK_ITEMS) send_color(HUE_W'($urandom()), rand_level(), rand_level(),
                                      BYTE_W'($urandom()));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_lightness  = '0;
    in_alpha_in   = '0;
    out_ready     = 1'b0;
    items_sent     = 0;
    colors_checked = 0;
    fail_count     = 0;
    idle_cycles    = 0;
    send_gap_max   = 0;
    recv_gap_max   = 0;
    hold_request   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_back_pressure();
    test_random_colors();
    in_valid <= 1'b0;

    // drain, then allow for stray results
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_colors.size() != 0) begin
      $error("%0d colors never came out", expected_colors.size());
      fail_count++;
    end

    $display("Covered %0d HSL items (corners, clamped levels, hue wrap, long output stall)",
             items_sent);
    $display("and compared %0d ARGB results field by field.", colors_checked);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/hsl2rgb_pkg.sv
src/hsl2rgb_front.sv
src/hsl2rgb_fifo.sv
src/hsl2rgb_back.sv
src/hsl_to_rgb_converter_unit.sv
src/hsl2rgb_checker.sv
verif/tb_top.sv
